[hdl/keyed_sorted_timer_table_defines.svh]
// Assertion macros shared by the timer table RTL.
`ifndef KEYED_SORTED_TIMER_TABLE_DEFINES_SVH
`define KEYED_SORTED_TIMER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KST_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_sorted_timer_table: assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_sorted_timer_table: assertion failed");
`else
`define KST_ASSERT_IMPL(label, ante, cons)
`define KST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/ksttbl_pkg.sv]
// Shared types, codes and constants of the sorted timer table.
package ksttbl_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_KEY_BITS    = 32;
    localparam int MAX_RESULTS     = 16;
    localparam logic [15:0] RETRY_INTERVAL = 16'd3;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic RK_REPLY  = 1'b0;
    localparam logic RK_NOTICE = 1'b1;

    localparam logic REG_MIN_GAP = 1'b0;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] interval;
        logic [31:0] tag;
        logic        is_local;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_GAP,
        S_HEAD,
        S_ARM,
        S_NOTE,
        S_FIN
    } state_t;

endpackage

[hdl/ksttbl_cell.sv]
// One slot of the sorted timer chain: holds an entry, shifts to or from its neighbors.
module ksttbl_cell #(
    parameter int KEY_BITS = ksttbl_pkg::DEF_KEY_BITS,
    parameter int IDXW     = 4,
    parameter int INDEX    = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ksttbl_pkg::cell_cmd_t  cmd,
    input  logic [KEY_BITS-1:0]    cmd_key,
    input  logic [IDXW-1:0]        rm_pos,
    input  logic                   left_valid,
    input  logic                   left_le,
    input  logic [KEY_BITS-1:0]    left_key,
    input  ksttbl_pkg::entry_t     left_ent,
    input  logic                   right_valid,
    input  logic [KEY_BITS-1:0]    right_key,
    input  ksttbl_pkg::entry_t     right_ent,
    output logic                   valid,
    output logic                   le,
    output logic                   match,
    output logic [KEY_BITS-1:0]    key,
    output ksttbl_pkg::entry_t     ent
);
    import ksttbl_pkg::*;

    localparam logic [IDXW-1:0] MY_INDEX = IDXW'(INDEX);

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    entry_t              ent_reg;
    entry_t              ent_next;

    // Compare own entry against the broadcast request
    assign le    = valid_reg && (ent_reg.deadline <= cmd.ent.deadline);
    assign match = valid_reg && (key_reg == cmd_key);
    assign valid = valid_reg;
    assign key   = key_reg;
    assign ent   = ent_reg;

    // Pick next content: hold, take new entry, or shift from a neighbor
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        ent_next   = ent_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        valid_next = 1'b1;
                        key_next   = cmd_key;
                        ent_next   = cmd.ent;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        key_next   = left_key;
                        ent_next   = left_ent;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (MY_INDEX >= rm_pos)
                begin
                    valid_next = right_valid;
                    key_next   = right_key;
                    ent_next   = right_ent;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ent_reg <= ent_next;
    end

endmodule

[hdl/keyed_sorted_timer_table.sv]
// Start/read/clear: lookup in S_LOOK, then S_EXEC once the output register is free.
// Tick: skip if under min gap; else one expired head per S_HEAD/S_ARM/S_NOTE pass, S_FIN.
// A new request is taken only in S_IDLE, once the previous one has run its sequence.
// Output register lets a new request in while the last result waits.
// Reset (rst_n, async low): all slots empty, last check time and min gap zero.
`include "keyed_sorted_timer_table_defines.svh"
module keyed_sorted_timer_table #(
    parameter int TABLE_DEPTH = ksttbl_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = ksttbl_pkg::DEF_KEY_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // timer_key[31:0] deadline[63:32] repeat_interval[79:64] user_tag[111:80]
    // is_local[112] now_time[144:113] delivery_blocked[145] zero[151:146]
    input  logic [151:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0] echo_kind[3:2] out_key[35:4] out_tag[67:36] zero[71:68]
    output logic [71:0]  m_axis_tdata,
    // result_kind[0]
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ksttbl_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(MAX_RESULTS + 1);

    // Request capture
    state_t              state_reg;
    state_t              state_next;
    logic [1:0]          kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    entry_t              req_ent_reg;
    logic [31:0]         now_reg;
    logic                blk_reg;

    // Lookup results
    logic                hit_reg;
    logic                full_reg;
    logic [31:0]         hit_tag_reg;
    logic [IDXW-1:0]     pos_reg;

    // Tick walk
    logic [31:0]         last_check_reg;
    logic [15:0]         gap_reg;
    logic [TABLE_DEPTH-1:0] snap_reg;
    logic [CNTW-1:0]     done_reg;
    logic [KEY_BITS-1:0] hd_key_reg;
    entry_t              hd_ent_reg;
    logic                pend_valid_reg;
    logic [KEY_BITS-1:0] pend_key_reg;
    logic [31:0]         pend_tag_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [1:0]          out_status_reg;
    logic [1:0]          out_echo_reg;
    logic [31:0]         out_key_reg;
    logic [31:0]         out_tag_reg;
    logic                out_last_reg;

    // Chain wires
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] le_vec;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [KEY_BITS-1:0]    key_arr [TABLE_DEPTH];
    entry_t                 ent_arr [TABLE_DEPTH];

    // Control
    cell_cmd_t           cmd;
    logic [KEY_BITS-1:0] cmd_key;
    logic [IDXW-1:0]     rm_pos;
    logic                in_fire;
    logic                out_free;
    logic                any_match;
    logic [31:0]         tag_sel;
    logic [IDXW-1:0]     pos_sel;
    logic                gap_skip;
    logic                head_stop;
    logic                note;
    logic                rearm;
    logic [32:0]         sum_iv;
    logic [32:0]         sum_retry;
    logic [31:0]         sat_iv;
    logic [31:0]         sat_retry;
    logic                out_load;
    logic                o_kind;
    logic [1:0]          o_status;
    logic [1:0]          o_echo;
    logic [31:0]         o_key;
    logic [31:0]         o_tag;
    logic                o_last;
    logic                head_cap;
    logic                pend_load;
    logic                pend_clear;
    logic                walk_step;
    logic                walk_init;
    logic                check_done;
    logic                cfg_write;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Cell chain
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic                lv;
        logic                ll;
        logic [KEY_BITS-1:0] lk;
        entry_t              lent;
        logic                rv;
        logic [KEY_BITS-1:0] rk;
        entry_t              rent;
        if (i == 0)
        begin : g_first
            assign lv   = 1'b1;
            assign ll   = 1'b1;
            assign lk   = cmd_key;
            assign lent = cmd.ent;
        end
        else
        begin : g_mid
            assign lv   = valid_vec[i-1];
            assign ll   = le_vec[i-1];
            assign lk   = key_arr[i-1];
            assign lent = ent_arr[i-1];
        end
        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign rv   = 1'b0;
            assign rk   = '0;
            assign rent = '0;
        end
        else
        begin : g_inner
            assign rv   = valid_vec[i+1];
            assign rk   = key_arr[i+1];
            assign rent = ent_arr[i+1];
        end
        ksttbl_cell #(
            .KEY_BITS (KEY_BITS),
            .IDXW     (IDXW),
            .INDEX    (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .cmd_key     (cmd_key),
            .rm_pos      (rm_pos),
            .left_valid  (lv),
            .left_le     (ll),
            .left_key    (lk),
            .left_ent    (lent),
            .right_valid (rv),
            .right_key   (rk),
            .right_ent   (rent),
            .valid       (valid_vec[i]),
            .le          (le_vec[i]),
            .match       (match_vec[i]),
            .key         (key_arr[i]),
            .ent         (ent_arr[i])
        );
    end

    // Gather the matching slot's tag and position
    always_comb
    begin
        tag_sel = '0;
        pos_sel = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                tag_sel = tag_sel | ent_arr[i].tag;
                pos_sel = pos_sel | IDXW'(i);
            end
        end
    end
    assign any_match = |match_vec;

    // Tick arithmetic
    assign gap_skip  = ((now_reg - last_check_reg) < {16'd0, gap_reg});
    assign head_stop = (done_reg == CNTW'(MAX_RESULTS)) || !snap_reg[0] || !valid_vec[0]
                       || (now_reg < ent_arr[0].deadline);
    assign note      = hd_ent_reg.is_local && !blk_reg;
    assign rearm     = (hd_ent_reg.interval != 16'd0) || (hd_ent_reg.is_local && blk_reg);
    assign sum_iv    = {1'b0, now_reg} + {17'd0, hd_ent_reg.interval};
    assign sum_retry = {1'b0, now_reg} + {17'd0, RETRY_INTERVAL};
    assign sat_iv    = sum_iv[32] ? '1 : sum_iv[31:0];
    assign sat_retry = sum_retry[32] ? '1 : sum_retry[31:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = (s_axis_tuser == KIND_TICK) ? S_GAP : S_LOOK;
            end
            S_LOOK: state_next = S_EXEC;
            S_EXEC:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_GAP:  state_next = gap_skip ? S_IDLE : S_HEAD;
            S_HEAD: state_next = head_stop ? S_FIN : S_ARM;
            S_ARM:  state_next = S_NOTE;
            S_NOTE:
            begin
                if (!(note && pend_valid_reg && !out_free))
                    state_next = S_HEAD;
            end
            S_FIN:
            begin
                if (!(pend_valid_reg && !out_free))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs per state
    always_comb
    begin
        cmd.op     = OP_HOLD;
        cmd.ent    = req_ent_reg;
        cmd_key    = key_reg;
        rm_pos     = '0;
        out_load   = 1'b0;
        o_kind     = RK_REPLY;
        o_status   = ST_OK;
        o_echo     = kind_reg;
        o_key      = 32'(key_reg);
        o_tag      = '0;
        o_last     = 1'b1;
        head_cap   = 1'b0;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        walk_step  = 1'b0;
        walk_init  = 1'b0;
        check_done = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (kind_reg == KIND_START)
                    begin
                        o_status = hit_reg ? ST_DUP : (full_reg ? ST_FULL : ST_OK);
                        if (!hit_reg && !full_reg)
                            cmd.op = OP_INSERT;
                    end
                    else
                    begin
                        o_status = hit_reg ? ST_OK : ST_NOTFOUND;
                        o_tag    = hit_reg ? hit_tag_reg : '0;
                        if (kind_reg == KIND_CLEAR && hit_reg)
                        begin
                            cmd.op = OP_REMOVE;
                            rm_pos = pos_reg;
                        end
                    end
                end
            end
            S_GAP:
            begin
                if (gap_skip)
                    walk_init = 1'b0;
                else
                    walk_init = 1'b1;
            end
            S_HEAD:
            begin
                if (!head_stop)
                begin
                    cmd.op   = OP_REMOVE;
                    head_cap = 1'b1;
                end
            end
            S_ARM:
            begin
                cmd_key = hd_key_reg;
                cmd.ent = hd_ent_reg;
                if (hd_ent_reg.interval != 16'd0)
                    cmd.ent.deadline = sat_iv;
                else
                begin
                    cmd.ent.deadline = sat_retry;
                    cmd.ent.interval = RETRY_INTERVAL;
                end
                if (rearm)
                    cmd.op = OP_INSERT;
            end
            S_NOTE:
            begin
                o_kind   = RK_NOTICE;
                o_echo   = KIND_TICK;
                o_key    = 32'(pend_key_reg);
                o_tag    = pend_tag_reg;
                o_last   = 1'b0;
                if (!(note && pend_valid_reg && !out_free))
                begin
                    walk_step = 1'b1;
                    if (note)
                    begin
                        pend_load = 1'b1;
                        out_load  = pend_valid_reg;
                    end
                end
            end
            S_FIN:
            begin
                o_kind = RK_NOTICE;
                o_echo = KIND_TICK;
                o_key  = 32'(pend_key_reg);
                o_tag  = pend_tag_reg;
                if (!(pend_valid_reg && !out_free))
                begin
                    check_done = 1'b1;
                    pend_clear = 1'b1;
                    out_load   = pend_valid_reg;
                end
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_check_reg <= '0;
            gap_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            done_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
                gap_reg <= pwdata[15:0];
            if (check_done)
                last_check_reg <= now_reg;
            if (walk_init || pend_clear)
                pend_valid_reg <= 1'b0;
            else if (pend_load)
                pend_valid_reg <= 1'b1;
            if (walk_init)
                done_reg <= '0;
            else if (walk_step)
                done_reg <= done_reg + CNTW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg             <= s_axis_tuser;
            key_reg              <= KEY_BITS'(s_axis_tdata[31:0]);
            req_ent_reg.deadline <= s_axis_tdata[63:32];
            req_ent_reg.interval <= s_axis_tdata[79:64];
            req_ent_reg.tag      <= s_axis_tdata[111:80];
            req_ent_reg.is_local <= s_axis_tdata[112];
            now_reg              <= s_axis_tdata[144:113];
            blk_reg              <= s_axis_tdata[145];
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg     <= any_match;
            full_reg    <= valid_vec[TABLE_DEPTH-1];
            hit_tag_reg <= tag_sel;
            pos_reg     <= pos_sel;
        end
        if (walk_init)
            snap_reg <= valid_vec;
        else if (walk_step)
            snap_reg <= snap_reg >> 1;
        if (head_cap)
        begin
            hd_key_reg <= key_arr[0];
            hd_ent_reg <= ent_arr[0];
        end
        if (pend_load)
        begin
            pend_key_reg <= hd_key_reg;
            pend_tag_reg <= hd_ent_reg.tag;
        end
        if (out_load)
        begin
            out_kind_reg   <= o_kind;
            out_status_reg <= o_status;
            out_echo_reg   <= o_echo;
            out_key_reg    <= o_key;
            out_tag_reg    <= o_tag;
            out_last_reg   <= o_last;
        end
    end

    // Stream output
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'd0, out_tag_reg, out_key_reg, out_echo_reg, out_status_reg};

    // Register port
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_GAP);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MIN_GAP) ? {16'd0, gap_reg} : 32'd0;

    // Checks
    `KST_ASSERT_NEXT(a_busy_after_accept, in_fire, state_reg != S_IDLE)
    `KST_ASSERT_IMPL(a_valid_prefix, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
    `KST_ASSERT_IMPL(a_pend_in_walk, pend_valid_reg,
        state_reg == S_HEAD || state_reg == S_ARM || state_reg == S_NOTE || state_reg == S_FIN)
    `KST_ASSERT_IMPL(a_done_bound, 1'b1, done_reg <= CNTW'(MAX_RESULTS))

endmodule
